// ----- rtl/potimer_pkg.sv -----
package potimer_pkg;

  // input kind codes
  localparam logic [2:0] KIND_CREATE_ONCE = 3'd0;
  localparam logic [2:0] KIND_CREATE_REP  = 3'd1;
  localparam logic [2:0] KIND_CANCEL      = 3'd2;
  localparam logic [2:0] KIND_CANCEL_ALL  = 3'd3;
  localparam logic [2:0] KIND_TICK        = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  // most timers fired by one tick
  localparam int RESULT_LIMIT = 32;
  localparam int FIRE_W       = 6;
  localparam int DROP_AW      = 5;

  localparam logic [47:0] DEADLINE_MAX = 48'hFFFF_FFFF_FFFF;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_CREATE,
    OP_CANCEL,
    OP_CLEAR,
    OP_TICK
  } op_t;

  typedef struct packed {
    op_t         op;
    logic        rep;
    logic [47:0] now_ms;
    logic [31:0] interval_ms;
    logic [31:0] timer_id;
  } cmd_t;

  typedef struct packed {
    logic [31:0] id;
    logic [47:0] deadline;
    logic [31:0] interval;
    logic        rep;
  } entry_t;

  // saturating 48-bit deadline advance
  function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [31:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {17'b0, b};
    return s[48] ? DEADLINE_MAX : s[47:0];
  endfunction

endpackage

// ----- rtl/potimer_ram.sv -----
module potimer_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

// ----- rtl/potimer_front.sv -----
module potimer_front
  import potimer_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_kind,
  input  logic [47:0] in_now_ms,
  input  logic [31:0] in_interval_ms,
  input  logic [31:0] in_timer_id,
  output logic        cmd_valid,
  output cmd_t        cmd,
  input  logic        cmd_pop
);

  cmd_t       q_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] fill_r;
  cmd_t       dec;
  logic       push;

  // classify the incoming kind
  always_comb begin
    dec.now_ms      = in_now_ms;
    dec.interval_ms = in_interval_ms;
    dec.timer_id    = in_timer_id;
    dec.rep         = (in_kind == KIND_CREATE_REP);
    case (in_kind)
      KIND_CREATE_ONCE: dec.op = OP_CREATE;
      KIND_CREATE_REP:  dec.op = OP_CREATE;
      KIND_CANCEL:      dec.op = OP_CANCEL;
      KIND_CANCEL_ALL:  dec.op = OP_CLEAR;
      KIND_TICK:        dec.op = OP_TICK;
      default:          dec.op = OP_NOP;
    endcase
  end

  assign in_ready  = (fill_r != 2'd2);
  assign push      = in_valid && in_ready;
  assign cmd_valid = (fill_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];

  // two-entry command queue
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= dec;
    end
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (cmd_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      fill_r <= fill_r + {1'b0, push} - {1'b0, cmd_pop};
    end
  end

endmodule

// ----- rtl/potimer_back.sv -----
module potimer_back
  import potimer_pkg::*;
#(
  parameter int MAX_TIMERS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cmd_valid,
  input  cmd_t        cmd,
  output logic        cmd_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [31:0] out_assigned_id,
  output logic        out_fired_valid,
  output logic [31:0] out_fired_id,
  output logic        out_last
);

  localparam int CW = $clog2(MAX_TIMERS + 1);
  localparam int AW = MAX_TIMERS > 1 ? $clog2(MAX_TIMERS) : 1;
  localparam int EW = $bits(entry_t);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EXEC  = 4'd1;
  localparam logic [3:0] S_CRD   = 4'd2;
  localparam logic [3:0] S_CCHK  = 4'd3;
  localparam logic [3:0] S_CMOVE = 4'd4;
  localparam logic [3:0] S_CDONE = 4'd5;
  localparam logic [3:0] S_TRD   = 4'd6;
  localparam logic [3:0] S_TCHK  = 4'd7;
  localparam logic [3:0] S_TEND  = 4'd8;
  localparam logic [3:0] S_DNEXT = 4'd9;

  logic [3:0]        state_r, state_nxt;
  cmd_t              cmd_r;
  logic [CW-1:0]     count_r, count_nxt;
  logic [31:0]       seq_r, seq_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [31:0]       rm_id_r, rm_id_nxt;
  logic              rm_drop_r, rm_drop_nxt;
  logic [1:0]        st_r, st_nxt;
  logic [FIRE_W-1:0] nfired_r, nfired_nxt;
  logic              pend_v_r, pend_v_nxt;
  logic [31:0]       pend_id_r, pend_id_nxt;
  logic [31:0]       drop_r [RESULT_LIMIT];
  logic [FIRE_W-1:0] ndrop_r, ndrop_nxt;
  logic [FIRE_W-1:0] dptr_r, dptr_nxt;
  logic              drop_push;

  logic              we, re;
  logic [AW-1:0]     waddr, raddr;
  entry_t            wdata, rd;
  logic [EW-1:0]     rdata;

  logic              out_free, emit;
  logic [1:0]        e_status;
  logic [31:0]       e_aid, e_fid;
  logic              e_fv, e_last;
  logic [CW-1:0]     idx_m1, count_m1;

  assign rd       = entry_t'(rdata);
  assign out_free = !out_valid || out_ready;
  assign idx_m1   = idx_r - CW'(1);
  assign count_m1 = count_r - CW'(1);

  potimer_ram #(.WIDTH(EW), .DEPTH(MAX_TIMERS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    seq_nxt     = seq_r;
    idx_nxt     = idx_r;
    rm_id_nxt   = rm_id_r;
    rm_drop_nxt = rm_drop_r;
    st_nxt      = st_r;
    nfired_nxt  = nfired_r;
    pend_v_nxt  = pend_v_r;
    pend_id_nxt = pend_id_r;
    ndrop_nxt   = ndrop_r;
    dptr_nxt    = dptr_r;
    drop_push   = 1'b0;
    cmd_pop     = 1'b0;
    we          = 1'b0;
    waddr       = count_r[AW-1:0];
    wdata       = rd;
    re          = 1'b0;
    raddr       = idx_r[AW-1:0];
    emit        = 1'b0;
    e_status    = ST_OK;
    e_aid       = 32'd0;
    e_fv        = 1'b0;
    e_fid       = 32'd0;
    e_last      = 1'b1;
    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop   = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (cmd_r.op)
          OP_CREATE: begin
            if (out_free) begin
              emit      = 1'b1;
              state_nxt = S_IDLE;
              if (count_r >= CW'(MAX_TIMERS)) begin
                e_status = ST_FULL;
              end else begin
                e_aid          = seq_r;
                we             = 1'b1;
                wdata.id       = seq_r;
                wdata.deadline = sat_add48(cmd_r.now_ms, cmd_r.interval_ms);
                wdata.interval = cmd_r.interval_ms;
                wdata.rep      = cmd_r.rep;
                count_nxt      = count_r + CW'(1);
                seq_nxt        = seq_r + 32'd1;
              end
            end
          end
          OP_CANCEL: begin
            idx_nxt     = count_r;
            rm_id_nxt   = cmd_r.timer_id;
            rm_drop_nxt = 1'b0;
            state_nxt   = S_CRD;
          end
          OP_TICK: begin
            idx_nxt    = '0;
            nfired_nxt = '0;
            pend_v_nxt = 1'b0;
            ndrop_nxt  = '0;
            state_nxt  = S_TRD;
          end
          OP_CLEAR: begin
            if (out_free) begin
              emit      = 1'b1;
              count_nxt = '0;
              state_nxt = S_IDLE;
            end
          end
          default: begin
            if (out_free) begin
              emit      = 1'b1;
              state_nxt = S_IDLE;
            end
          end
        endcase
      end
      // backward search for the id
      S_CRD: begin
        if (idx_r == '0) begin
          st_nxt    = ST_NOT_FOUND;
          state_nxt = rm_drop_r ? S_DNEXT : S_CDONE;
        end else begin
          re        = 1'b1;
          raddr     = idx_m1[AW-1:0];
          idx_nxt   = idx_m1;
          state_nxt = S_CCHK;
        end
      end
      S_CCHK: begin
        if (rd.id == rm_id_r) begin
          re        = 1'b1;
          raddr     = count_m1[AW-1:0];
          state_nxt = S_CMOVE;
        end else begin
          state_nxt = S_CRD;
        end
      end
      // last entry fills the hole
      S_CMOVE: begin
        we        = 1'b1;
        waddr     = idx_r[AW-1:0];
        wdata     = rd;
        count_nxt = count_m1;
        st_nxt    = ST_OK;
        state_nxt = rm_drop_r ? S_DNEXT : S_CDONE;
      end
      S_CDONE: begin
        if (out_free) begin
          emit      = 1'b1;
          e_status  = st_r;
          state_nxt = S_IDLE;
        end
      end
      // forward scan for due timers
      S_TRD: begin
        if (idx_r >= count_r || nfired_r == FIRE_W'(RESULT_LIMIT)) begin
          state_nxt = S_TEND;
        end else begin
          re        = 1'b1;
          state_nxt = S_TCHK;
        end
      end
      S_TCHK: begin
        if (rd.deadline > cmd_r.now_ms) begin
          idx_nxt   = idx_r + CW'(1);
          state_nxt = S_TRD;
        end else if (!pend_v_r || out_free) begin
          if (pend_v_r) begin
            emit   = 1'b1;
            e_fv   = 1'b1;
            e_fid  = pend_id_r;
            e_last = 1'b0;
          end
          pend_v_nxt  = 1'b1;
          pend_id_nxt = rd.id;
          nfired_nxt  = nfired_r + FIRE_W'(1);
          if (rd.rep) begin
            we             = 1'b1;
            waddr          = idx_r[AW-1:0];
            wdata          = rd;
            wdata.deadline = sat_add48(rd.deadline, rd.interval);
          end else begin
            drop_push = 1'b1;
            ndrop_nxt = ndrop_r + FIRE_W'(1);
          end
          idx_nxt   = idx_r + CW'(1);
          state_nxt = S_TRD;
        end
      end
      S_TEND: begin
        if (out_free) begin
          emit      = 1'b1;
          e_fv      = pend_v_r;
          e_fid     = pend_v_r ? pend_id_r : 32'd0;
          dptr_nxt  = '0;
          state_nxt = S_DNEXT;
        end
      end
      // remove fired one-shot timers by id
      S_DNEXT: begin
        if (dptr_r == ndrop_r) begin
          state_nxt = S_IDLE;
        end else begin
          rm_id_nxt   = drop_r[dptr_r[DROP_AW-1:0]];
          rm_drop_nxt = 1'b1;
          dptr_nxt    = dptr_r + FIRE_W'(1);
          idx_nxt     = count_r;
          state_nxt   = S_CRD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cmd_r <= cmd;
    end
    if (drop_push) begin
      drop_r[ndrop_r[DROP_AW-1:0]] <= rd.id;
    end
    if (emit) begin
      out_status      <= e_status;
      out_assigned_id <= e_aid;
      out_fired_valid <= e_fv;
      out_fired_id    <= e_fid;
      out_last        <= e_last;
    end
    idx_r     <= idx_nxt;
    rm_id_r   <= rm_id_nxt;
    st_r      <= st_nxt;
    pend_id_r <= pend_id_nxt;
    dptr_r    <= dptr_nxt;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      seq_r     <= '0;
      rm_drop_r <= 1'b0;
      nfired_r  <= '0;
      pend_v_r  <= 1'b0;
      ndrop_r   <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      seq_r     <= seq_nxt;
      rm_drop_r <= rm_drop_nxt;
      nfired_r  <= nfired_nxt;
      pend_v_r  <= pend_v_nxt;
      ndrop_r   <= ndrop_nxt;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/periodic_and_oneshot_timer_table.sv -----
// Table of one-shot and repeating millisecond timers.
// Input channel (in_valid/in_ready): kind selects create one-shot, create
// repeating, cancel by id, cancel all or tick; now_ms, interval_ms and
// timer_id carry the operands. A two-entry command queue takes transfers
// while the sequencer works on an earlier one.
// Result channel (out_valid/out_ready): one transfer per create, cancel,
// cancel-all or unknown kind; a tick gives one transfer per fired timer
// (at most 32) or one with out_fired_valid low. out_last marks the final
// transfer of each command.
// Entries sit in one RAM with a registered read port; a scan reads one
// entry and checks it in the following state. Cancel searches backward from
// the last entry; a tick scans forward, then removes each fired one-shot by id.
// Commands are carried out one at a time.
// Reset clears the entry count and the id sequence; no clearing pass.
// When the receiver stalls, the result register holds and the sequencer
// waits, while the queue keeps taking commands until it is full.
module periodic_and_oneshot_timer_table
  import potimer_pkg::*;
#(
  parameter int MAX_TIMERS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_kind,
  input  logic [47:0] in_now_ms,
  input  logic [31:0] in_interval_ms,
  input  logic [31:0] in_timer_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [31:0] out_assigned_id,
  output logic        out_fired_valid,
  output logic [31:0] out_fired_id,
  output logic        out_last
);

  logic cmd_valid, cmd_pop;
  cmd_t cmd;

  potimer_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_now_ms      (in_now_ms),
    .in_interval_ms (in_interval_ms),
    .in_timer_id    (in_timer_id),
    .cmd_valid      (cmd_valid),
    .cmd            (cmd),
    .cmd_pop        (cmd_pop)
  );

  potimer_back #(.MAX_TIMERS(MAX_TIMERS)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (cmd_valid),
    .cmd             (cmd),
    .cmd_pop         (cmd_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_assigned_id (out_assigned_id),
    .out_fired_valid (out_fired_valid),
    .out_fired_id    (out_fired_id),
    .out_last        (out_last)
  );

endmodule

// ----- tb/sv/timer_table_checker.sv -----
module timer_table_checker
  import potimer_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  in_kind,
  input  logic [47:0] in_now_ms,
  input  logic [31:0] in_interval_ms,
  input  logic [31:0] in_timer_id,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_status,
  input  logic [31:0] out_assigned_id,
  input  logic        out_fired_valid,
  input  logic [31:0] out_fired_id,
  input  logic        out_last,
  output int          fail_count,
  output int          pending_results,
  output int          fired_seen,
  output int          full_seen,
  output int          miss_seen
);

  localparam int TABLE_DEPTH = 32;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] assigned_id;
    logic        fired_valid;
    logic [31:0] fired_id;
    logic        last;
  } timer_result_t;

  timer_result_t expected_q[$];

  // shadow copy of the timer table
  logic [31:0] tbl_id   [TABLE_DEPTH];
  logic [47:0] tbl_due  [TABLE_DEPTH];
  logic [31:0] tbl_ivl  [TABLE_DEPTH];
  logic        tbl_rep  [TABLE_DEPTH];
  int          tbl_count;
  logic [31:0] seq_id;

  function automatic logic [47:0] add_sat(logic [47:0] a, logic [31:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {17'd0, b};
    return s[48] ? 48'hFFFF_FFFF_FFFF : s[47:0];
  endfunction

  function automatic bit drop_timer(logic [31:0] id);
    for (int i = tbl_count - 1; i >= 0; i--) begin
      if (tbl_id[i] == id) begin
        tbl_id[i]  = tbl_id[tbl_count-1];
        tbl_due[i] = tbl_due[tbl_count-1];
        tbl_ivl[i] = tbl_ivl[tbl_count-1];
        tbl_rep[i] = tbl_rep[tbl_count-1];
        tbl_count--;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void push_result(logic [1:0] st, logic [31:0] aid, logic fv,
                                      logic [31:0] fid, logic lst);
    timer_result_t r;
    r.status = st; r.assigned_id = aid; r.fired_valid = fv;
    r.fired_id = fid; r.last = lst;
    expected_q.push_back(r);
  endfunction

  // work out the results of one command transfer
  task automatic apply_command(logic [2:0] kind, logic [47:0] now, logic [31:0] ivl,
                               logic [31:0] tid);
    logic [31:0] gone[$];
    int n;
    case (kind)
      KIND_CREATE_ONCE, KIND_CREATE_REP: begin
        if (tbl_count >= TABLE_DEPTH) begin
          push_result(ST_FULL, 32'd0, 1'b0, 32'd0, 1'b1);
          full_seen++;
        end else begin
          tbl_id[tbl_count]  = seq_id;
          tbl_due[tbl_count] = add_sat(now, ivl);
          tbl_ivl[tbl_count] = ivl;
          tbl_rep[tbl_count] = (kind == KIND_CREATE_REP);
          tbl_count++;
          push_result(ST_OK, seq_id, 1'b0, 32'd0, 1'b1);
          seq_id++;
        end
      end
      KIND_CANCEL: begin
        if (drop_timer(tid)) begin
          push_result(ST_OK, 32'd0, 1'b0, 32'd0, 1'b1);
        end else begin
          push_result(ST_NOT_FOUND, 32'd0, 1'b0, 32'd0, 1'b1);
          miss_seen++;
        end
      end
      KIND_CANCEL_ALL: begin
        tbl_count = 0;
        push_result(ST_OK, 32'd0, 1'b0, 32'd0, 1'b1);
      end
      KIND_TICK: begin
        n = 0;
        for (int i = 0; i < tbl_count; i++) begin
          if (n >= RESULT_LIMIT) break;
          if (tbl_due[i] <= now) begin
            push_result(ST_OK, 32'd0, 1'b1, tbl_id[i], 1'b0);
            n++;
            fired_seen++;
            if (tbl_rep[i]) tbl_due[i] = add_sat(tbl_due[i], tbl_ivl[i]);
            else gone.push_back(tbl_id[i]);
          end
        end
        if (n == 0) push_result(ST_OK, 32'd0, 1'b0, 32'd0, 1'b1);
        else expected_q[$].last = 1'b1;
        foreach (gone[k]) void'(drop_timer(gone[k]));
      end
      default: push_result(ST_OK, 32'd0, 1'b0, 32'd0, 1'b1);
    endcase
  endtask

  assign pending_results = expected_q.size();

  // observe both channels at each edge
  always @(posedge clk) begin
    timer_result_t want;
    if (!rst_n) begin
      tbl_count <= 0;
      seq_id <= '0;
      fail_count <= 0;
      fired_seen <= 0;
      full_seen <= 0;
      miss_seen <= 0;
      expected_q.delete();
    end else begin
      if (in_valid && in_ready)
        apply_command(in_kind, in_now_ms, in_interval_ms, in_timer_id);
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result transfer: st=%0d aid=%0d fv=%0b fid=%0d last=%0b",
                     out_status, out_assigned_id, out_fired_valid, out_fired_id, out_last);
        end else begin
          want = expected_q.pop_front();
          if (want.status !== out_status || want.assigned_id !== out_assigned_id ||
              want.fired_valid !== out_fired_valid || want.fired_id !== out_fired_id ||
              want.last !== out_last) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: exp st=%0d aid=%0d fv=%0b fid=%0d last=%0b, got st=%0d aid=%0d fv=%0b fid=%0d last=%0b",
                       want.status, want.assigned_id, want.fired_valid, want.fired_id,
                       want.last, out_status, out_assigned_id, out_fired_valid,
                       out_fired_id, out_last);
          end
        end
      end
    end
  end

endmodule

// ----- tb/sv/tb.sv -----
module tb;
  import potimer_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_kind = KIND_TICK;
  logic [47:0] in_now_ms = '0;
  logic [31:0] in_interval_ms = '0;
  logic [31:0] in_timer_id = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic [31:0] out_assigned_id;
  logic        out_fired_valid;
  logic [31:0] out_fired_id;
  logic        out_last;

  int fail_count, pending_results, fired_seen, full_seen, miss_seen;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_off = 0;
  logic [47:0] clock_ms = '0;
  logic [31:0] ids_issued = '0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  periodic_and_oneshot_timer_table i_dut (.*);

  timer_table_checker i_check (.*);

  // receiver: random stall plus an optional long hold-off
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // offer one command and wait for its transfer
  task automatic send_cmd(logic [2:0] kind, logic [47:0] now, logic [31:0] ivl,
                          logic [31:0] tid);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_now_ms <= now;
    in_interval_ms <= ivl;
    in_timer_id <= tid;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (kind == KIND_CREATE_ONCE || kind == KIND_CREATE_REP) ids_issued++;
  endtask

  // mixed traffic: mostly creates and ticks, plus cancels, cancel-all and unknown kinds
  task automatic random_cmd();
    int pick;
    logic [31:0] ivl;
    logic [31:0] tid;
    pick = $urandom_range(99);
    case ($urandom_range(3))
      0: ivl = $urandom_range(3);
      1: ivl = $urandom_range(200);
      2: ivl = $urandom_range(3000);
      default: ivl = $urandom;
    endcase
    tid = ($urandom_range(3) == 0 || ids_issued == 0) ? $urandom
          : ids_issued - 1 - $urandom_range(ids_issued > 40 ? 40 : ids_issued - 1);
    if ($urandom_range(49) == 0) clock_ms = 48'({$urandom, $urandom});
    if (pick < 25) send_cmd(KIND_CREATE_ONCE, clock_ms, ivl, $urandom);
    else if (pick < 45) send_cmd(KIND_CREATE_REP, clock_ms, ivl, $urandom);
    else if (pick < 58) send_cmd(KIND_CANCEL, clock_ms, $urandom, tid);
    else if (pick < 60) send_cmd(KIND_CANCEL_ALL, clock_ms, $urandom, $urandom);
    else if (pick < 62) send_cmd(3'($urandom_range(7, 5)), clock_ms, $urandom, $urandom);
    else begin
      clock_ms = clock_ms + $urandom_range(400);
      send_cmd(KIND_TICK, clock_ms, $urandom, $urandom);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, all kinds, full table, wrap, saturation
    send_cmd(KIND_TICK, 48'd0, 32'd0, 32'd0);
    send_cmd(KIND_CANCEL, 48'd0, 32'd0, 32'd0);
    send_cmd(KIND_CREATE_REP, 48'd5, 32'd0, 32'd0);
    send_cmd(KIND_CREATE_ONCE, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_cmd(KIND_CREATE_REP, 48'hFFFF_FFFF_0000, 32'hFFFF_FFFF, 32'd0);
    send_cmd(KIND_CREATE_ONCE, 48'd10, 32'd5, 32'd0);
    send_cmd(KIND_TICK, 48'd20, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_cmd(KIND_TICK, 48'd20, 32'd0, 32'd0);
    send_cmd(KIND_TICK, 48'hFFFF_FFFF_FFFF, 32'd0, 32'd0);
    send_cmd(KIND_CANCEL, 48'd0, 32'd0, 32'd1);
    send_cmd(KIND_CANCEL, 48'd0, 32'd0, 32'hFFFF_FFFF);
    send_cmd(3'd5, 48'd0, 32'd0, 32'd0);
    send_cmd(3'd7, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_cmd(KIND_CANCEL_ALL, 48'd0, 32'd0, 32'd0);
    // fill past the limit, then tick twice with every timer due
    for (int i = 0; i < 33; i++) send_cmd(3'(i & 1), 48'd100, 32'(i % 3), 32'd0);
    send_cmd(KIND_TICK, 48'd200, 32'd0, 32'd0);
    send_cmd(KIND_TICK, 48'd200, 32'd0, 32'd0);
    send_cmd(KIND_CANCEL_ALL, 48'd0, 32'd0, 32'd0);
    clock_ms = 48'd1000;

    // random phases with different idling
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 36 : (ph == 1) ? 72 : 0;
      recv_idle_pct = (ph == 0) ? 72 : (ph == 1) ? 36 : 0;
      if (ph == 2) hold_off = 400;
      for (int n = 0; n < 150; n++) random_cmd();
    end

    in_valid <= 1'b0;
    while (pending_results != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("ran %0d creates issued, %0d fires, %0d full creates, %0d cancel misses",
             ids_issued, fired_seen, full_seen, miss_seen);
    if (fail_count == 0 && pending_results == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #50000000;
    $display("Verification failed");
    $finish;
  end

endmodule
